>>> src/slip_deframer_crc16_check_core_macros.svh
// Assertion macros for the SLIP deframer with CRC-16 check.
// Used by the port-level checker; needs a clock and an active-high reset.
`ifndef SLIP_DEFRAMER_CRC16_CHECK_CORE_MACROS_SVH
`define SLIP_DEFRAMER_CRC16_CHECK_CORE_MACROS_SVH

// same-cycle implication
`define SDFCRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdfcrc assertion failed");

// next-cycle implication
`define SDFCRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdfcrc assertion failed");

`endif

>>> src/sdfcrc_pkg.sv
// Package for the SLIP deframer with CRC-16 check: codes, types, CRC update.
// No dependencies.
`timescale 1ns / 1ps

package sdfcrc_pkg;

   localparam logic [7:0] FEND  = 8'hC0;
   localparam logic [7:0] FESC  = 8'hDB;
   localparam logic [7:0] TFEND = 8'hDC;
   localparam logic [7:0] TFESC = 8'hDD;

   localparam logic [1:0] KIND_DATA      = 2'd0;
   localparam logic [1:0] KIND_GOOD      = 2'd1;
   localparam logic [1:0] KIND_CRC_ERROR = 2'd2;
   localparam logic [1:0] KIND_SHORT     = 2'd3;

   localparam logic [7:0] MIN_LENGTH_RESET = 8'd8;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } stage_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] frame_length;
   } result_type;

   function automatic logic [15:0] crc_byte_update(input logic [7:0] b,
                                                  input logic [15:0] acc);
      logic [15:0] a;
      a = acc ^ {8'h00, b};
      a = {a[7:0], a[15:8]};
      a = a ^ {a[11:8], 12'h000};
      a = a ^ {12'h000, a[15:12]};
      a = a ^ {5'b00000, a[15:8], 3'b000};
      return a;
   endfunction

endpackage

>>> src/sdfcrc_req_if.sv
// Input channel carrying one raw received byte per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface sdfcrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> src/sdfcrc_rsp_if.sv
// Result channel carrying data bytes and frame verdicts.
// Depends on nothing.
`timescale 1ns / 1ps

interface sdfcrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic [7:0] frame_length;

   modport source (output valid, output kind, output data_byte, output frame_length,
                   input ready);
   modport sink (input valid, input kind, input data_byte, input frame_length,
                 output ready);
endinterface

>>> src/sdfcrc_in_stage.sv
// Input register of the deframer: holds one received byte until the core takes it.
// Depends on sdfcrc_pkg.
`timescale 1ns / 1ps

module sdfcrc_in_stage
   import sdfcrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   output logic       req_ready,
   input  logic       take,
   output stage_type  stage
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       accept;

   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

>>> src/sdfcrc_frame_core.sv
// Frame state, unescape, CRC update and result register of the deframer.
// Depends on sdfcrc_pkg.
`timescale 1ns / 1ps

module sdfcrc_frame_core
   import sdfcrc_pkg::*;
#(
   parameter int FRAME_CAPACITY = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  stage_type  stage,
   output logic       take,
   input  logic       rsp_ready,
   output result_type result
);

   localparam int CountWidth = $clog2(FRAME_CAPACITY + 1);

   logic                  pend_ff, pend_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [15:0]           crc_ff, crc_in;
   logic [7:0]            held0_ff, held0_in;
   logic [7:0]            held1_ff, held1_in;
   logic [7:0]            min_ff;
   logic                  rvalid_ff, rvalid_in;
   logic [1:0]            kind_ff, kind_in;
   logic [7:0]            data_ff, data_in;
   logic [7:0]            len_ff, len_in;
   logic [7:0]            plain_byte;
   logic                  load;

   assign take = stage.valid && (!rvalid_ff || rsp_ready);

   always_comb begin
      pend_in    = pend_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      load       = 1'b0;
      kind_in    = KIND_DATA;
      data_in    = 8'h00;
      len_in     = 8'h00;
      plain_byte = stage.rx_byte;
      if (pend_ff) begin
         case (stage.rx_byte)
            TFEND:   plain_byte = FEND;
            TFESC:   plain_byte = FESC;
            default: plain_byte = stage.rx_byte;
         endcase
      end
      if (take) begin
         case (stage.rx_byte)
            FESC: begin
               pend_in = 1'b1;
            end
            FEND: begin
               load = 1'b1;
               len_in = 8'(count_ff);
               if (count_ff < CountWidth'(2) || 8'(count_ff) < min_ff) begin
                  kind_in = KIND_SHORT;
               end else if ({held1_ff, held0_ff} == crc_ff) begin
                  kind_in = KIND_GOOD;
               end else begin
                  kind_in = KIND_CRC_ERROR;
               end
               pend_in  = 1'b0;
               count_in = '0;
               crc_in   = 16'h0000;
               held0_in = 8'h00;
               held1_in = 8'h00;
            end
            default: begin
               pend_in = 1'b0;
               if (count_ff < CountWidth'(FRAME_CAPACITY)) begin
                  if (count_ff >= CountWidth'(2)) begin
                     crc_in = crc_byte_update(held0_ff, crc_ff);
                  end
                  held0_in = held1_ff;
                  held1_in = plain_byte;
                  count_in = count_ff + CountWidth'(1);
                  load     = 1'b1;
                  data_in  = plain_byte;
               end
            end
         endcase
      end
      rvalid_in = load || (rvalid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         count_ff  <= '0;
         crc_ff    <= 16'h0000;
         held0_ff  <= 8'h00;
         held1_ff  <= 8'h00;
         min_ff    <= MIN_LENGTH_RESET;
         rvalid_ff <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         held0_ff  <= held0_in;
         held1_ff  <= held1_in;
         rvalid_ff <= rvalid_in;
         if (csr_wr_en) begin
            min_ff <= csr_wr_data;
         end
      end
      if (load) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         len_ff  <= len_in;
      end
   end

   assign result.valid        = rvalid_ff;
   assign result.kind         = kind_ff;
   assign result.data_byte    = data_ff;
   assign result.frame_length = len_ff;

endmodule

>>> src/slip_deframer_crc16_check_core.sv
// SLIP deframer with CRC-16 check, top level.
// Path: an accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while the result side takes items; set by the
// single frame-state stage (unescape plus one CRC byte update).
// Reset: synchronous, clears frame state and both valids; minimum length to 8.
`timescale 1ns / 1ps

module slip_deframer_crc16_check_core
   import sdfcrc_pkg::*;
#(
   parameter int FRAME_CAPACITY = 128
) (
   input  logic       clock,
   input  logic       reset,
   sdfcrc_req_if.sink   req_ch,
   sdfcrc_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   stage_type  stage;
   result_type result;
   logic       take;

   sdfcrc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_rx_byte (req_ch.rx_byte),
      .req_ready   (req_ch.ready),
      .take        (take),
      .stage       (stage)
   );

   sdfcrc_frame_core #(
      .FRAME_CAPACITY (FRAME_CAPACITY)
   ) u_frame_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stage       (stage),
      .take        (take),
      .rsp_ready   (rsp_ch.ready),
      .result      (result)
   );

   assign rsp_ch.valid        = result.valid;
   assign rsp_ch.kind         = result.kind;
   assign rsp_ch.data_byte    = result.data_byte;
   assign rsp_ch.frame_length = result.frame_length;

endmodule

>>> src/sdfcrc_checker.sv
// Port-level checker for the SLIP deframer with CRC-16 check, bound to the top level.
// Depends on sdfcrc_pkg and slip_deframer_crc16_check_core_macros.svh.
`timescale 1ns / 1ps
`include "slip_deframer_crc16_check_core_macros.svh"

module sdfcrc_checker
   import sdfcrc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [7:0] rsp_frame_length
);

   `SDFCRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte) && $stable(rsp_frame_length))
   `SDFCRC_ASSERT_IMPLY(a_data_no_length, clock, reset, rsp_valid && rsp_kind == KIND_DATA,
      rsp_frame_length == 8'd0)
   `SDFCRC_ASSERT_IMPLY(a_verdict_no_data, clock, reset, rsp_valid && rsp_kind != KIND_DATA,
      rsp_data_byte == 8'd0)
   `SDFCRC_ASSERT_IMPLY(a_checked_min_two, clock, reset,
      rsp_valid && (rsp_kind == KIND_GOOD || rsp_kind == KIND_CRC_ERROR),
      rsp_frame_length >= 8'd2)

endmodule

bind slip_deframer_crc16_check_core sdfcrc_checker u_sdfcrc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_kind         (rsp_ch.kind),
   .rsp_data_byte    (rsp_ch.data_byte),
   .rsp_frame_length (rsp_ch.frame_length)
);

>>> test/sdfcrc_frame_checker.sv
// Result checker for the SLIP deframer with CRC-16 check: tracks frame state, predicts each
// result and compares it with what the result channel delivers.
// Depends on sdfcrc_pkg and the sdfcrc_req_if / sdfcrc_rsp_if interfaces.
`timescale 1ns / 1ps

module sdfcrc_frame_checker
   import sdfcrc_pkg::*;
#(
   parameter int FRAME_CAPACITY = 128
) (
   input  logic       clock,
   input  logic       reset,
   sdfcrc_req_if      req_mon,
   sdfcrc_rsp_if      rsp_mon,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         mismatch_count,
   output int         results_owed
);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] frame_length;
   } rsp_item_type;

   rsp_item_type owed_q[$];
   logic         esc_pending;
   logic [7:0]   stored_n;
   logic [15:0]  crc_acc;
   logic [7:0]   hold_old;
   logic [7:0]   hold_new;
   logic [7:0]   min_len;
   int           fails = 0;

   assign mismatch_count = fails;

   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] x;
      x = acc ^ {8'h00, b};
      x = {x[7:0], x[15:8]};
      x = x ^ ((x & 16'hFF00) << 4);
      x = x ^ (x >> 12);
      x = x ^ ((x & 16'hFF00) >> 5);
      return x;
   endfunction

   task automatic clear_frame();
      esc_pending = 1'b0;
      stored_n    = 8'd0;
      crc_acc     = 16'h0000;
      hold_old    = 8'h00;
      hold_new    = 8'h00;
   endtask

   task automatic report_mismatch(input string what, input int want_v, input int got_v);
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want_v, got_v);
      fails++;
   endtask

   task automatic predict_rx(input logic [7:0] raw);
      logic [7:0]   b;
      rsp_item_type item;
      b = raw;
      if (b == FESC) begin
         esc_pending = 1'b1;
      end else if (b == FEND) begin
         item.kind = KIND_SHORT;
         if (stored_n >= 8'd2 && stored_n >= min_len)
            item.kind = ({hold_new, hold_old} == crc_acc) ? KIND_GOOD : KIND_CRC_ERROR;
         item.data_byte    = 8'h00;
         item.frame_length = stored_n;
         owed_q.push_back(item);
         clear_frame();
      end else begin
         if (esc_pending) begin
            if (b == TFEND)
               b = FEND;
            else if (b == TFESC)
               b = FESC;
            esc_pending = 1'b0;
         end
         // drop bytes once the frame is full
         if (int'(stored_n) < FRAME_CAPACITY) begin
            if (stored_n >= 8'd2)
               crc_acc = crc16_step(crc_acc, hold_old);
            hold_old = hold_new;
            hold_new = b;
            stored_n = stored_n + 8'd1;
            item.kind         = KIND_DATA;
            item.data_byte    = b;
            item.frame_length = 8'd0;
            owed_q.push_back(item);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         clear_frame();
         min_len = MIN_LENGTH_RESET;
         owed_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.kind         = rsp_mon.kind;
            got.data_byte    = rsp_mon.data_byte;
            got.frame_length = rsp_mon.frame_length;
            if (owed_q.size() == 0) begin
               report_mismatch("unexpected item, kind", -1, got.kind);
            end else begin
               want = owed_q.pop_front();
               if (got.kind !== want.kind)
                  report_mismatch("kind", want.kind, got.kind);
               if (got.data_byte !== want.data_byte)
                  report_mismatch("data_byte", want.data_byte, got.data_byte);
               if (got.frame_length !== want.frame_length)
                  report_mismatch("frame_length", want.frame_length, got.frame_length);
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_rx(req_mon.rx_byte);
         if (csr_wr_en)
            min_len = csr_wr_data;
      end
      results_owed <= owed_q.size();
   end

endmodule

>>> test/tb_slip_deframer_crc16_check_core.sv
// Testbench top for the SLIP deframer with CRC-16 check: drives escaped frames, noise and
// minimum-length settings with random idling on both channels, and gives the verdict.
// Depends on sdfcrc_pkg, both channel interfaces, sdfcrc_frame_checker and the block.
`timescale 1ns / 1ps

module tb_slip_deframer_crc16_check_core;
   import sdfcrc_pkg::*;

   localparam int FRAME_CAPACITY = 128;
   localparam int STIM_ITEMS     = 1900;
   localparam int IDLE_LIMIT     = 3000;
   localparam int LONG_HOLD      = 300;

   typedef logic [7:0] octet_type;

   localparam octet_type OPENING [15] = '{
      FEND,
      8'h00, 8'hFF, FEND,
      FESC, TFEND, FESC, TFESC, FESC, 8'h41,
      FESC, FESC, 8'h11, FESC, FEND
   };
   localparam octet_type MIN_EXTREMES [6] = '{8'd3, 8'd128, 8'd0, 8'd1, 8'd255, 8'd8};

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;
   int         mismatch_count;
   int         results_owed;
   int         items_sent;
   int         idle_cycles = 0;
   bit         steady_flow;
   bit         hold_request;

   sdfcrc_req_if req_ch ();
   sdfcrc_rsp_if rsp_ch ();

   slip_deframer_crc16_check_core #(
      .FRAME_CAPACITY(FRAME_CAPACITY)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   sdfcrc_frame_checker #(
      .FRAME_CAPACITY(FRAME_CAPACITY)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .results_owed  (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 70)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic octet_type pick_content();
      if ($urandom_range(0, 9) < 3) begin
         case ($urandom_range(0, 3))
            0: return FEND;
            1: return FESC;
            2: return TFEND;
            default: return TFESC;
         endcase
      end
      return octet_type'($urandom_range(0, 255));
   endfunction

   function automatic logic [15:0] frame_crc(input octet_type body[$]);
      logic [15:0] acc;
      acc = 16'h0000;
      foreach (body[i]) begin
         acc = acc ^ {8'h00, body[i]};
         acc = {acc[7:0], acc[15:8]};
         acc = acc ^ ((acc << 4) & 16'hF000);
         acc = acc ^ (acc >> 12);
         acc = acc ^ ((acc >> 5) & 16'h07F8);
      end
      return acc;
   endfunction

   task automatic send_byte(input octet_type b);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do
         @(posedge clock);
      while (!(req_ch.valid && req_ch.ready));
      items_sent++;
   endtask

   task automatic send_frame(input octet_type body[$], input bit seal, input bit corrupt);
      logic [15:0] crc;
      int          pos;
      if (seal) begin
         crc = frame_crc(body);
         body.push_back(crc[7:0]);
         body.push_back(crc[15:8]);
      end
      if (corrupt && body.size() > 0) begin
         pos = $urandom_range(0, body.size() - 1);
         body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      foreach (body[i]) begin
         if (body[i] == FEND) begin
            send_byte(FESC);
            send_byte(TFEND);
         end else if (body[i] == FESC) begin
            send_byte(FESC);
            send_byte(TFESC);
         end else begin
            send_byte(body[i]);
         end
      end
      send_byte(FEND);
   endtask

   task automatic write_min_len(input octet_type value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // hold the input idle until nothing is owed, then let the pipeline settle
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (results_owed != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      int      stall_left;
      int      roll;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (steady_flow || roll < 75) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               stall_left = (roll < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
               rsp_ch.ready <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL slip_deframer_crc16_check_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      octet_type body[$];
      octet_type min_setting;
      int        phase;
      int        frames;
      int        n;
      int        roll;
      int        size_roll;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 8'h00;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      items_sent     = 0;
      steady_flow    = 1'b0;
      hold_request   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty frame, short frames, every escape form, END while pending
      foreach (OPENING[i])
         send_byte(OPENING[i]);
      wait_drained();
      write_min_len(8'd3);
      body = '{8'hA5};
      send_frame(body, 1'b1, 1'b0);
      body = '{8'h01, 8'h02, 8'h03};
      send_frame(body, 1'b0, 1'b0);
      body = '{FEND};
      send_frame(body, 1'b1, 1'b1);

      phase = 0;
      while (items_sent < STIM_ITEMS + 25) begin
         wait_drained();
         if (phase < 6)
            min_setting = MIN_EXTREMES[phase];
         else if ($urandom_range(0, 9) < 3)
            min_setting = MIN_EXTREMES[$urandom_range(0, 5)];
         else
            min_setting = octet_type'($urandom_range(3, 128));
         write_min_len(min_setting);
         steady_flow = ($urandom_range(0, 4) == 0) || (phase == 2);
         // stall the result side while items keep coming
         if (phase == 2)
            hold_request = 1'b1;
         frames = $urandom_range(6, 14);
         for (int k = 0; k < frames; k++) begin
            roll      = $urandom_range(0, 99);
            size_roll = $urandom_range(0, 99);
            if (phase == 1 && k == 0)
               n = 130;
            else if (size_roll < 88)
               n = $urandom_range(0, 10);
            else if (size_roll < 98)
               n = $urandom_range(11, 40);
            else
               n = $urandom_range(120, 135);
            body.delete();
            repeat (n) body.push_back(pick_content());
            if (roll < 72) begin
               send_frame(body, 1'b1, roll >= 58);
            end else if (roll < 87) begin
               send_frame(body, 1'b0, 1'b0);
            end else begin
               repeat ($urandom_range(0, 12)) send_byte(pick_content());
               if (roll >= 95)
                  send_byte(FESC);
               send_byte(FEND);
            end
         end
         phase++;
      end
      steady_flow = 1'b0;
      wait_drained();

      if (mismatch_count == 0 && results_owed == 0)
         $display("PASS slip_deframer_crc16_check_core");
      else
         $display("FAIL slip_deframer_crc16_check_core");
      $finish;
   end

endmodule
